[sv/hysteresis_bar_quantizer_macros.svh]
// ============================================================================
// hysteresis_bar_quantizer_macros: assertion helpers
// concurrent assertion wrappers for hbq_checker.sv, the only checker among the files
// ============================================================================
`ifndef HYSTERESIS_BAR_QUANTIZER_MACROS_SVH
`define HYSTERESIS_BAR_QUANTIZER_MACROS_SVH

// same-cycle implication
`define HBQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HBQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hbq_pkg.sv]
// ============================================================================
// hbq_pkg: shared types and constants
// widths, register codes, divider stage type and divider step function
// ============================================================================
`timescale 1ns / 1ps

package hbq_pkg;

  localparam int COLUMN_COUNT = 16;
  localparam int TOP_LEVEL    = 15;

  localparam int COL_W   = 4;
  localparam int SLOT_W  = $clog2(COLUMN_COUNT);
  localparam int LEVEL_W = 4;
  localparam int MV_W    = 17;
  localparam int CELL_W  = 5;
  localparam int RANGE_W = 13;
  localparam int HYST_W  = 7;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 13;

  // range limits: 13 bit times 5 bit
  localparam int DEN_W = RANGE_W + CELL_W;
  // quotient tq <= TOP_LEVEL * 256
  localparam int Q_W   = 12;
  // numerator (v - lo) * TOP_LEVEL * 256 with v - lo < 2^17
  localparam int NUM_W = MV_W + Q_W;
  localparam int QBIT_W = $clog2(Q_W);

  localparam logic [Q_W-1:0]     HALF_Q8   = Q_W'(128);
  localparam logic [LEVEL_W-1:0] TOP_CODE  = LEVEL_W'(TOP_LEVEL);

  typedef enum logic [IDX_W-1:0] {
    REG_RANGE_LOW   = 3'd0,
    REG_RANGE_HIGH  = 3'd1,
    REG_HYSTERESIS  = 3'd2,
    REG_WARN_FIRST  = 3'd3,
    REG_WARN_SECOND = 3'd4
  } hbq_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic             force_zero;
    logic             force_top;
  } hbq_tag_t;

  typedef struct packed {
    logic             valid;
    hbq_tag_t         tag;
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
  } hbq_div_t;

  // one restoring step: try den shifted to quotient bit bitpos
  function automatic hbq_div_t div_step(input hbq_div_t s, input logic [QBIT_W-1:0] bitpos);
    logic [NUM_W:0] trial;
    hbq_div_t       r;
    trial = {{(NUM_W + 1 - DEN_W){1'b0}}, s.den} << bitpos;
    r = s;
    if ({1'b0, s.rem} >= trial) begin
      r.rem         = NUM_W'({1'b0, s.rem} - trial);
      r.quo[bitpos] = 1'b1;
    end
    return r;
  endfunction

endpackage

[sv/hbq_if.sv]
// ============================================================================
// hbq_if: channel interfaces
// sample, result and configuration write channels with valid/ready
// ============================================================================
`timescale 1ns / 1ps

interface hbq_sample_if import hbq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   column;
  logic [MV_W-1:0]    sample_mv;
  logic [CELL_W-1:0]  cell_count;

  modport source (output valid, output column, output sample_mv, output cell_count,
                  input ready);
  modport sink   (input valid, input column, input sample_mv, input cell_count,
                  output ready);
endinterface

interface hbq_result_if import hbq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   out_column;
  logic [LEVEL_W-1:0] level;
  logic               warn_first;
  logic               warn_second;

  modport source (output valid, output out_column, output level, output warn_first,
                  output warn_second, input ready);
  modport sink   (input valid, input out_column, input level, input warn_first,
                  input warn_second, output ready);
endinterface

interface hbq_cfg_if import hbq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/hbq_div.sv]
// ============================================================================
// hbq_div: pipelined restoring divider
// one quotient bit per stage, msb first, tag carried alongside
// ============================================================================
`timescale 1ns / 1ps

module hbq_div import hbq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  hbq_div_t din,
  output hbq_div_t dout
);

  hbq_div_t stage [Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Q_W; i++) begin
        stage[i].valid <= 1'b0;
      end
    end else if (en) begin
      stage[0] <= div_step(din, QBIT_W'(Q_W - 1));
      for (int i = 1; i < Q_W; i++) begin
        stage[i] <= div_step(stage[i-1], QBIT_W'(Q_W - 1 - i));
      end
    end
  end

  assign dout = stage[Q_W-1];

endmodule

[sv/hysteresis_bar_quantizer.sv]
// ============================================================================
// hysteresis_bar_quantizer: bar level quantizer with per-column hysteresis
// one item accepted per cycle sustained while the result channel does not stall
// pipelined through the 12-stage divider (one quotient bit per stage) and a registered level ram read
// sync reset: config to defaults, pipeline empty, every column level reads as zero
// ============================================================================
`timescale 1ns / 1ps

module hysteresis_bar_quantizer import hbq_pkg::*; (
  input  logic clk,
  input  logic rst,
  hbq_sample_if.sink   sample,
  hbq_result_if.source result,
  hbq_cfg_if.sink      cfg
);

  // --------------------------------------------------------------------------
  // configuration registers, always ready
  // --------------------------------------------------------------------------
  logic [RANGE_W-1:0] range_low_mv;
  logic [RANGE_W-1:0] range_high_mv;
  logic [HYST_W-1:0]  hysteresis_q8;
  logic [LEVEL_W-1:0] warn_first_level;
  logic [LEVEL_W-1:0] warn_second_level;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low_mv      <= RANGE_W'(2800);
      range_high_mv     <= RANGE_W'(4300);
      hysteresis_q8     <= HYST_W'(64);
      warn_first_level  <= LEVEL_W'(7);
      warn_second_level <= LEVEL_W'(3);
    end else if (cfg.valid) begin
      unique case (hbq_reg_t'(cfg.index))
        REG_RANGE_LOW:   range_low_mv      <= cfg.data[RANGE_W-1:0];
        REG_RANGE_HIGH:  range_high_mv     <= cfg.data[RANGE_W-1:0];
        REG_HYSTERESIS:  hysteresis_q8     <= cfg.data[HYST_W-1:0];
        REG_WARN_FIRST:  warn_first_level  <= cfg.data[LEVEL_W-1:0];
        REG_WARN_SECOND: warn_second_level <= cfg.data[LEVEL_W-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control
  // the whole pipe shifts together; it may shift while a result waits
  // in the output register as long as the final stage holds a bubble
  // --------------------------------------------------------------------------
  logic res_valid;
  logic f_valid;
  logic load;
  logic en;

  assign load         = !res_valid || result.ready;
  assign en           = load || !f_valid;
  assign sample.ready = en;

  // --------------------------------------------------------------------------
  // stage 1: scale the range by the cell count
  // --------------------------------------------------------------------------
  logic               s1_valid;
  logic [COL_W-1:0]   s1_column;
  logic [MV_W-1:0]    s1_v;
  logic [DEN_W-1:0]   s1_lo;
  logic [DEN_W-1:0]   s1_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_column <= sample.column;
      s1_v      <= sample.sample_mv;
      s1_lo     <= DEN_W'(range_low_mv) * DEN_W'(sample.cell_count);
      s1_hi     <= DEN_W'(range_high_mv) * DEN_W'(sample.cell_count);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: range checks, numerator (v - lo) * 15 * 256, denominator hi - lo
  // --------------------------------------------------------------------------
  logic [DEN_W-1:0] s1_v_ext;
  logic             below;
  logic             above;
  logic [MV_W-1:0]  diff;
  hbq_div_t         div_in;
  hbq_div_t         div_out;

  assign s1_v_ext = DEN_W'(s1_v);
  assign below    = s1_v_ext < s1_lo;
  assign above    = s1_v_ext > s1_hi;
  // only meaningful when lo <= v, where v - lo fits the sample width
  assign diff     = MV_W'(s1_v_ext - s1_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_in.valid <= 1'b0;
    end else if (en) begin
      div_in.valid <= s1_valid;
    end
    if (en) begin
      div_in.tag.column     <= s1_column;
      // below range wins, then above range, then an empty range
      div_in.tag.force_zero <= below || (!above && (s1_hi <= s1_lo));
      div_in.tag.force_top  <= !below && above;
      // times 15 as times 16 minus one, then the q8 shift
      div_in.rem            <= {diff, 12'b0} - NUM_W'({diff, 8'b0});
      div_in.den            <= s1_hi - s1_lo;
      div_in.quo            <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // stages 3 to 14: pipelined divide, tq = num / den
  // --------------------------------------------------------------------------
  hbq_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (div_in),
    .dout (div_out)
  );

  // --------------------------------------------------------------------------
  // column level memory: read as the item enters the final stage,
  // written as it leaves; an item one behind on the same column takes
  // the level through the forward path since the read saw the old entry
  // --------------------------------------------------------------------------
  logic [LEVEL_W-1:0]      level_mem [COLUMN_COUNT];
  logic [COLUMN_COUNT-1:0] level_written;
  logic [LEVEL_W-1:0]      rd_level;
  logic                    rd_written;
  logic                    fwd_hit;
  logic [LEVEL_W-1:0]      fwd_level;
  logic                    wr_en;
  logic [SLOT_W-1:0]       rd_slot;
  logic [SLOT_W-1:0]       wr_slot;

  hbq_div_t           f;
  logic [LEVEL_W-1:0] f_level;

  assign f_valid = f.valid;
  assign wr_en   = f.valid && load;
  assign rd_slot = div_out.tag.column[SLOT_W-1:0];
  assign wr_slot = f.tag.column[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      level_mem[wr_slot] <= f_level;
    end
    if (en) begin
      rd_level <= level_mem[rd_slot];
    end
  end

  // entry valid bits give the all-zero reset without a clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      level_written <= '0;
    end else if (wr_en) begin
      level_written[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f.valid    <= 1'b0;
      rd_written <= 1'b0;
      fwd_hit    <= 1'b0;
    end else if (en) begin
      f.valid    <= div_out.valid;
      rd_written <= level_written[rd_slot];
      fwd_hit    <= f.valid && (f.tag.column == div_out.tag.column);
    end
    if (en) begin
      f.tag     <= div_out.tag;
      f.rem     <= div_out.rem;
      f.den     <= div_out.den;
      f.quo     <= div_out.quo;
      fwd_level <= f_level;
    end
  end

  // --------------------------------------------------------------------------
  // stage 15: rounding with hysteresis against the stored level
  // --------------------------------------------------------------------------
  logic [LEVEL_W-1:0] cur_level;
  logic [Q_W-1:0]     rounded;
  logic [Q_W-1:0]     rounded_up;
  logic [Q_W-1:0]     rounded_dn;
  logic [LEVEL_W-1:0] base;

  assign cur_level  = fwd_hit ? fwd_level : (rd_written ? rd_level : '0);
  // tq <= 3840, so adding a half step plus the hysteresis stays in 12 bits
  assign rounded    = f.quo + HALF_Q8;
  assign rounded_up = rounded - Q_W'(hysteresis_q8);
  assign rounded_dn = rounded + Q_W'(hysteresis_q8);
  assign base       = rounded[Q_W-1:8];

  always_comb begin
    if (f.tag.force_zero) begin
      f_level = '0;
    end else if (f.tag.force_top) begin
      f_level = TOP_CODE;
    end else if (base > cur_level) begin
      // rising: harder to step up
      f_level = rounded_up[Q_W-1:8];
    end else if (base < cur_level) begin
      // falling: harder to step down
      f_level = rounded_dn[Q_W-1:8];
    end else begin
      f_level = base;
    end
  end

  // --------------------------------------------------------------------------
  // stage 16: output register
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]   res_column;
  logic [LEVEL_W-1:0] res_level;
  logic               res_warn_first;
  logic               res_warn_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_column      <= f.tag.column;
      res_level       <= f_level;
      res_warn_first  <= f_level <= warn_first_level;
      res_warn_second <= f_level <= warn_second_level;
    end
  end

  assign result.valid       = res_valid;
  assign result.out_column  = res_column;
  assign result.level       = res_level;
  assign result.warn_first  = res_warn_first;
  assign result.warn_second = res_warn_second;

endmodule

[sv/hbq_checker.sv]
// ============================================================================
// hbq_checker: port-level checks for the quantizer
// result channel behavior seen from the top level ports
// ============================================================================
`timescale 1ns / 1ps
`include "hysteresis_bar_quantizer_macros.svh"

module hbq_checker import hbq_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COL_W-1:0]   out_column,
  input logic [LEVEL_W-1:0] level,
  input logic               warn_first,
  input logic               warn_second
);

  // a stalled result stays offered
  `HBQ_ASSERT_NEXT(a_res_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // and keeps its payload
  `HBQ_ASSERT_NEXT(a_res_stable, clk, rst, out_valid && !out_ready, $stable(out_column) && $stable(level) && $stable(warn_first) && $stable(warn_second), "result changed while stalled")

  // nothing comes out right after reset
  `HBQ_ASSERT_IMPL(a_reset_empty, clk, rst, $past(rst), !out_valid, "result valid after reset")

  // level zero is at or below any warning threshold
  `HBQ_ASSERT_IMPL(a_zero_warns, clk, rst, out_valid && (level == '0), warn_first && warn_second, "empty bar without warnings")

endmodule

bind hysteresis_bar_quantizer hbq_checker u_hbq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_column  (result.out_column),
  .level       (result.level),
  .warn_first  (result.warn_first),
  .warn_second (result.warn_second)
);

[tb/sv/hysteresis_bar_quantizer_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// hysteresis_bar_quantizer_tb: self-checking bench for the bar level quantizer
// drives voltage samples through several range, hysteresis and warning
// settings with random idle cycles on both channels, predicts the bar level of
// every column and compares each result against the oldest expected one
// ============================================================================

module hysteresis_bar_quantizer_tb;
  import hbq_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 24;      // beyond the pipeline latency
  localparam int HOLD_CYCLES   = 120;     // long receiver stall, fills the pipeline
  localparam int LIMIT_CYCLES  = 200000;
  localparam int REPORT_MAX    = 10;
  localparam int MV_MAX        = (1 << MV_W) - 1;

  // register values after reset
  localparam int RESET_RANGE_LOW  = 2800;
  localparam int RESET_RANGE_HIGH = 4300;
  localparam int RESET_HYST       = 64;
  localparam int RESET_WARN_FIRST = 7;
  localparam int RESET_WARN_SEC   = 3;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [LEVEL_W-1:0] level;
    logic               warn_first;
    logic               warn_second;
  } bar_result_t;

  // --------------------------------------------------------------------------
  // bar level predictor and store of expected results
  // --------------------------------------------------------------------------
  class bar_level_board;
    logic [RANGE_W-1:0] range_low;
    logic [RANGE_W-1:0] range_high;
    logic [HYST_W-1:0]  hyst;
    logic [LEVEL_W-1:0] warn_first_lvl;
    logic [LEVEL_W-1:0] warn_second_lvl;
    logic [7:0]         stored_level [COLUMN_COUNT];
    bar_result_t        expected_bars [$];
    int                 mismatches;

    function new();
      range_low       = RANGE_W'(RESET_RANGE_LOW);
      range_high      = RANGE_W'(RESET_RANGE_HIGH);
      hyst            = HYST_W'(RESET_HYST);
      warn_first_lvl  = LEVEL_W'(RESET_WARN_FIRST);
      warn_second_lvl = LEVEL_W'(RESET_WARN_SEC);
      foreach (stored_level[i]) stored_level[i] = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] index, logic [DATA_W-1:0] data);
      case (index)
        REG_RANGE_LOW:   range_low       = data[RANGE_W-1:0];
        REG_RANGE_HIGH:  range_high      = data[RANGE_W-1:0];
        REG_HYSTERESIS:  hyst            = data[HYST_W-1:0];
        REG_WARN_FIRST:  warn_first_lvl  = data[LEVEL_W-1:0];
        REG_WARN_SECOND: warn_second_lvl = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // scaled range, q8 position, rounding with hysteresis against the stored level
    function void note_sample(logic [COL_W-1:0] col, logic [MV_W-1:0] mv,
                              logic [CELL_W-1:0] cells);
      longint unsigned lo, hi, tq, base, cur, lvl, half, hy;
      int              slot;
      bar_result_t     res;
      slot = int'(col) % COLUMN_COUNT;
      lo   = 64'(range_low) * 64'(cells);
      hi   = 64'(range_high) * 64'(cells);
      cur  = 64'(stored_level[slot]);
      half = 64'(HALF_Q8);
      hy   = 64'(hyst);
      if (64'(mv) < lo)
        lvl = 0;
      else if (64'(mv) > hi)
        lvl = 64'(TOP_LEVEL);
      else if (hi <= lo)
        lvl = 0;
      else begin
        tq   = ((64'(mv) - lo) * 64'(TOP_LEVEL) * 256) / (hi - lo);
        base = (tq + half) >> 8;
        if (base > cur)
          lvl = (tq + half - hy) >> 8;
        else if (base < cur)
          lvl = (tq + half + hy) >> 8;
        else
          lvl = base;
      end
      stored_level[slot] = lvl[7:0];
      res.column      = col;
      res.level       = lvl[LEVEL_W-1:0];
      res.warn_first  = (lvl <= 64'(warn_first_lvl));
      res.warn_second = (lvl <= 64'(warn_second_lvl));
      expected_bars.push_back(res);
    endfunction

    function void flag(string what, int exp_val, int got_val);
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    endfunction

    function void check_result(bar_result_t got);
      bar_result_t exp;
      if (expected_bars.size() == 0) begin
        flag("unexpected result, column", -1, got.column);
        return;
      end
      exp = expected_bars.pop_front();
      if (got.column !== exp.column) flag("out_column", exp.column, got.column);
      if (got.level !== exp.level) flag("level", exp.level, got.level);
      if (got.warn_first !== exp.warn_first)
        flag("warn_first", exp.warn_first, got.warn_first);
      if (got.warn_second !== exp.warn_second)
        flag("warn_second", exp.warn_second, got.warn_second);
    endfunction
  endclass

  logic clk;
  logic rst;

  hbq_sample_if sample_ch ();
  hbq_result_if result_ch ();
  hbq_cfg_if    cfg_ch ();

  hysteresis_bar_quantizer i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  bar_level_board board;

  bit   tx_busy;              // sender draws idle cycles per item
  bit   rx_busy;              // receiver draws stall cycles per item
  logic hold_go = 1'b0;       // request for the long receiver stall
  logic rx_hold;
  int   rx_wait;
  int   cycle_count = 0;
  logic [MV_W-1:0] last_mv [COLUMN_COUNT];

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // run limit, far above the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // long stall of the receiver, counted here while the sender keeps offering
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // result side: check each accepted item, then pick the stall before the next one
  always @(posedge clk) begin : rx_side
    int stall;
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_wait         <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        board.check_result({result_ch.out_column, result_ch.level,
                            result_ch.warn_first, result_ch.warn_second});
      if (rx_hold)
        result_ch.ready <= 1'b0;
      else if (result_ch.valid && result_ch.ready) begin
        stall = rx_busy ? $urandom_range(0, 4) : 0;
        if (stall == 0)
          result_ch.ready <= 1'b1;
        else begin
          result_ch.ready <= 1'b0;
          rx_wait         <= stall - 1;
        end
      end else if (!result_ch.ready) begin
        if (rx_wait > 0)
          rx_wait <= rx_wait - 1;
        else
          result_ch.ready <= 1'b1;
      end
    end
  end

  // one register write; valid is left high for a following write
  task automatic write_reg(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.write_reg(index, data);
  endtask

  // full register set; unused data bits carry junk, and one write to a free index
  task automatic apply_setting(input int lo_mv, input int hi_mv, input int hyst,
                               input int warn1, input int warn2);
    logic [DATA_W-1:0] junk;
    junk = DATA_W'($urandom);
    write_reg(REG_RANGE_LOW, DATA_W'(lo_mv));
    write_reg(REG_RANGE_HIGH, DATA_W'(hi_mv));
    write_reg(REG_HYSTERESIS, {junk[DATA_W-1:HYST_W], HYST_W'(hyst)});
    write_reg(REG_WARN_FIRST, {junk[DATA_W-1:LEVEL_W], LEVEL_W'(warn1)});
    write_reg(REG_WARN_SECOND, {junk[DATA_W-1:LEVEL_W], LEVEL_W'(warn2)});
    // index past the register list: accepted and dropped
    write_reg(IDX_W'(REG_WARN_SECOND) + IDX_W'($urandom_range(1, 3)), junk);
    cfg_ch.valid <= 1'b0;
  endtask

  // offer one sample after a random gap and wait for the handshake
  task automatic send_sample(input logic [COL_W-1:0] col, input int mv, input int cells);
    int gap;
    gap = tx_busy ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.column     <= col;
    sample_ch.sample_mv  <= MV_W'(mv);
    sample_ch.cell_count <= CELL_W'(cells);
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    board.note_sample(col, MV_W'(mv), CELL_W'(cells));
    last_mv[int'(col) % COLUMN_COUNT] = MV_W'(mv);
  endtask

  // sender stops until every expected result is back, then the pipeline empties
  task automatic settle();
    sample_ch.valid <= 1'b0;
    while (board.expected_bars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random samples, mostly inside the scaled range or drifting around the last
  // value of the column so that hysteresis and back-to-back columns are hit
  task automatic run_random(input int count, input bit tx, input bit rx);
    int     cells, kind, mv, spread;
    longint lo, hi, drift;
    logic [COL_W-1:0] col;
    tx_busy = tx;
    rx_busy = rx;
    repeat (count) begin
      kind = $urandom_range(0, 19);
      if (kind == 0)
        cells = 0;
      else if (kind < 3)
        cells = $urandom_range(17, 31);
      else
        cells = $urandom_range(1, 16);
      // a few hot columns most of the time
      col = ($urandom_range(0, 1) == 0) ? COL_W'($urandom_range(0, 2))
                                        : COL_W'($urandom_range(0, 15));
      lo = longint'(board.range_low) * cells;
      hi = longint'(board.range_high) * cells;
      if (lo > MV_MAX) lo = MV_MAX;
      if (hi > MV_MAX) hi = MV_MAX;
      kind = $urandom_range(0, 9);
      case (kind)
        0: mv = $urandom_range(0, MV_MAX);
        1: mv = (lo > 0) ? $urandom_range(0, int'(lo) - 1) : 0;
        2: mv = (hi < MV_MAX) ? $urandom_range(int'(hi) + 1, MV_MAX) : MV_MAX;
        3: mv = ($urandom_range(0, 1) == 0) ? int'(lo) : int'(hi);
        4, 5, 6: begin
          // small drift around the previous sample of this column
          spread = (hi > lo) ? int'((hi - lo) / 30) + 1 : 1;
          drift  = longint'(last_mv[int'(col) % COLUMN_COUNT])
                   + $urandom_range(0, 2 * spread) - spread;
          if (drift < 0) drift = 0;
          if (drift > MV_MAX) drift = MV_MAX;
          mv = int'(drift);
        end
        default: mv = (hi > lo) ? $urandom_range(int'(lo), int'(hi)) : int'(lo);
      endcase
      send_sample(col, mv, cells);
    end
    settle();
  endtask

  initial begin
    int lo_mv, hi_mv;
    board = new();
    foreach (last_mv[i]) last_mv[i] = MV_W'(3500);
    rst                  = 1'b1;
    tx_busy              = 1'b0;
    rx_busy              = 1'b0;
    sample_ch.valid      = 1'b0;
    sample_ch.column     = '0;
    sample_ch.sample_mv  = '0;
    sample_ch.cell_count = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with the reset settings: 2800..4300 mV per cell, 100 mV a step
    send_sample(4'd0, 0, 1);             // below range
    send_sample(4'd1, 2800, 1);          // exactly the low limit
    send_sample(4'd1, 4300, 1);          // exactly the high limit
    send_sample(4'd1, 4301, 1);          // just above range
    send_sample(4'd2, 0, 0);             // zero cells, zero sample: empty range
    send_sample(4'd2, 1, 0);             // zero cells, any nonzero voltage is above range
    send_sample(4'd3, 68800, 16);        // pack total at the top
    send_sample(4'd3, 44799, 16);        // pack total just below range
    send_sample(4'd15, MV_MAX, 31);      // widest sample and cell count
    // one column walking around the 7/8 rounding point, hysteresis holds the bar
    send_sample(4'd4, 3560, 1);
    send_sample(4'd4, 3560, 1);
    send_sample(4'd4, 3590, 1);
    send_sample(4'd4, 3540, 1);
    send_sample(4'd4, 3500, 1);
    send_sample(4'd4, 3100, 1);          // warnings at both levels
    send_sample(4'd5, 3150, 1);
    send_sample(4'd5, 3150, 1);          // same column back to back
    send_sample(4'd10, 21000, 6);
    settle();

    // long receiver stall while the sender streams: input stalls on a full pipe
    apply_setting(2800, 4300, 127, 15, 0);
    hold_go = 1'b1;
    run_random(60, 1'b0, 1'b1);

    // widest range, no hysteresis
    apply_setting(0, 8191, 0, 0, 15);
    run_random(50, 1'b1, 1'b1);

    // empty range at the top of the field
    apply_setting(8191, 8191, 64, 7, 3);
    run_random(40, 1'b1, 1'b0);

    // inverted range: with cells present only below and above remain
    apply_setting(5000, 1000, 32, 10, 5);
    run_random(40, 1'b0, 1'b1);

    // narrow range, strong hysteresis
    apply_setting(3000, 3100, 100, 12, 2);
    run_random(60, 1'b1, 1'b1);

    // one millivolt range
    apply_setting(0, 1, 127, 15, 15);
    run_random(30, 1'b0, 1'b0);

    // random settings, idling switched per phase
    repeat (4) begin
      lo_mv = $urandom_range(0, 7000);
      hi_mv = lo_mv + $urandom_range(1, 1191);
      apply_setting(lo_mv, hi_mv, $urandom_range(0, 127), $urandom_range(0, 15),
                    $urandom_range(0, 15));
      run_random(45, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end

    if (board.mismatches == 0 && board.expected_bars.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/hbq_pkg.sv
sv/hbq_if.sv
sv/hbq_div.sv
sv/hysteresis_bar_quantizer.sv
sv/hbq_checker.sv
tb/sv/hysteresis_bar_quantizer_tb.sv
